>>> rtl/sm3_pkg.sv
// SM3 package: beat types, initial value, round constants and round helper functions.
// No dependencies; every module of the hash block imports it.
`default_nettype none
package sm3_pkg;

  typedef struct packed {
    logic [31:0] msg_word;
    logic [2:0]  byte_count;
    logic        last;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_digest;
  } digest_t;

  // One padded block word between front and back; fin marks the end of a message.
  typedef struct packed {
    logic [31:0] word;
    logic        fin;
  } qent_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;

  localparam logic [31:0] IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // Round constant T_j rotated left by j mod 32.
  function automatic logic [31:0] tconst(input logic [5:0] j);
    return rotl((j < 6'd16) ? T_LOW : T_HIGH, j[4:0]);
  endfunction

endpackage
`default_nettype wire

>>> rtl/sm3_front.sv
// SM3 front end: accepts message beats, applies padding and the length trailer.
// Depends on sm3_pkg; feeds padded block words into the word queue.
`default_nettype none
module sm3_front
  import sm3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire msg_t  msg,
  output logic       q_push,
  output qent_t      q_data,
  input  wire logic  q_full
);

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_PAD80  = 3'd1;
  localparam logic [2:0] F_ZERO   = 3'd2;
  localparam logic [2:0] F_LEN_HI = 3'd3;
  localparam logic [2:0] F_LEN_LO = 3'd4;

  logic [2:0]  state, state_next;
  logic [63:0] bit_len;
  logic [3:0]  wib;
  logic [3:0]  wib_inc;
  logic        acc;
  logic [2:0]  cnt;
  logic [5:0]  nbits;
  logic [31:0] mask, pad;

  assign full    = (state != F_IDLE) || q_full;
  assign acc     = push && !full;
  assign cnt     = (msg.byte_count > 3'd4 || !msg.last) ? 3'd4 : msg.byte_count;
  assign nbits   = {cnt, 3'b000};
  assign mask    = (cnt == 3'd0) ? 32'h0 : ~(32'hFFFFFFFF >> nbits);
  assign pad     = 32'h80000000 >> nbits;
  assign wib_inc = wib + 4'd1;

  always_comb begin
    q_push     = 1'b0;
    q_data     = '{word: 32'h0, fin: 1'b0};
    state_next = state;
    case (state)
      F_IDLE: begin
        if (acc) begin
          q_push = 1'b1;
          if (msg.last && cnt != 3'd4) begin
            q_data.word = (msg.msg_word & mask) | pad;
            state_next  = (wib_inc == 4'd14) ? F_LEN_HI : F_ZERO;
          end else begin
            q_data.word = msg.msg_word;
            if (msg.last) state_next = F_PAD80;
          end
        end
      end
      F_PAD80: begin
        q_push      = !q_full;
        q_data.word = 32'h80000000;
        if (!q_full) state_next = (wib_inc == 4'd14) ? F_LEN_HI : F_ZERO;
      end
      F_ZERO: begin
        q_push = !q_full;
        if (!q_full && wib_inc == 4'd14) state_next = F_LEN_HI;
      end
      F_LEN_HI: begin
        q_push      = !q_full;
        q_data.word = bit_len[63:32];
        if (!q_full) state_next = F_LEN_LO;
      end
      F_LEN_LO: begin
        q_push = !q_full;
        q_data = '{word: bit_len[31:0], fin: 1'b1};
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      bit_len <= 64'h0;
      wib     <= 4'h0;
    end else begin
      state <= state_next;
      if (q_push) wib <= wib_inc;
      if (acc) begin
        bit_len <= bit_len + {58'h0, nbits};
      end else if (state == F_LEN_LO && !q_full) begin
        bit_len <= 64'h0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/sm3_queue.sv
// Short word queue that decouples the padding front end from the compression core.
// Depends on sm3_pkg for the entry type and depth.
`default_nettype none
module sm3_queue
  import sm3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire qent_t wdata,
  output logic       full,
  input  wire logic  pop,
  output qent_t      rdata,
  output logic       empty
);

  qent_t          mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   cnt;

  assign full  = (cnt == (QAW+1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/sm3_core.sv
// SM3 compression core: loads 16 words, runs 64 rounds, keeps the chaining value.
// Depends on sm3_pkg; drains the digest through an eight-word output buffer.
`default_nettype none
module sm3_core
  import sm3_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  wire qent_t q_data,
  output logic       q_pop,
  output logic       empty,
  input  wire logic  pop,
  output digest_t    digest
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  logic [1:0]  state;
  logic [5:0]  rnd;
  logic        fin;
  logic [31:0] chain [8];
  logic [31:0] r [8];
  logic [31:0] w [16];
  logic [31:0] obuf [8];
  logic [3:0]  out_cnt;

  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wnew;
  logic        done_go;

  assign q_pop   = (state == S_LOAD) && !q_empty;
  assign done_go = (state == S_DONE) && (!fin || out_cnt == 4'd0);

  always_comb begin
    a12  = rotl(r[0], 5'd12);
    ss1  = rotl(a12 + r[4] + tconst(rnd), 5'd7);
    ss2  = ss1 ^ a12;
    if (rnd < 6'd16) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1  = ff + r[3] + ss2 + (w[0] ^ w[4]);
    tt2  = gg + r[7] + ss1 + w[0];
    wnew = perm1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
  end

  always_ff @(posedge clk) begin
    if (q_pop || state == S_ROUND) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= q_pop ? q_data.word : wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      rnd     <= 6'd0;
      fin     <= 1'b0;
      out_cnt <= 4'd0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= IV[i];
        r[i]     <= 32'h0;
      end
    end else begin
      if (pop && out_cnt != 4'd0) begin
        for (int i = 0; i < 7; i++) obuf[i] <= obuf[i+1];
        out_cnt <= out_cnt - 4'd1;
      end
      case (state)
        S_LOAD: begin
          if (q_pop) begin
            rnd <= rnd + 6'd1;
            if (rnd == 6'd15) begin
              fin   <= q_data.fin;
              rnd   <= 6'd0;
              state <= S_ROUND;
              for (int i = 0; i < 8; i++) r[i] <= chain[i];
            end
          end
        end
        S_ROUND: begin
          r[3] <= r[2];
          r[2] <= rotl(r[1], 5'd9);
          r[1] <= r[0];
          r[0] <= tt1;
          r[7] <= r[6];
          r[6] <= rotl(r[5], 5'd19);
          r[5] <= r[4];
          r[4] <= perm0(tt2);
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_DONE;
        end
        S_DONE: begin
          if (done_go) begin
            state <= S_LOAD;
            if (fin) begin
              for (int i = 0; i < 8; i++) begin
                obuf[i]  <= chain[i] ^ r[i];
                chain[i] <= IV[i];
              end
              out_cnt <= 4'd8;
            end else begin
              for (int i = 0; i < 8; i++) chain[i] <= chain[i] ^ r[i];
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign empty  = (out_cnt == 4'd0);
  assign digest = '{digest_word: obuf[0],
                    word_index:  3'(4'd8 - out_cnt),
                    last_digest: (out_cnt == 4'd1)};

  a_out_cnt_range: assert property (@(posedge clk) disable iff (rst)
    out_cnt <= 4'd8) else $error("output count out of range");
  a_pop_only_load: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_LOAD) else $error("queue read outside load");
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == 6'd63) |=> state == S_DONE)
    else $error("round sequence broke");
  a_digest_load: assert property (@(posedge clk) disable iff (rst)
    (done_go && fin) |-> out_cnt == 4'd0) else $error("digest overwrote output");

endmodule
`default_nettype wire

>>> rtl/sm3_hash.sv
// SM3 hash top level: front end with padding, word queue, compression core.
// Depends on sm3_pkg, sm3_front, sm3_queue and sm3_core.
//
//   Channel   Handshake          Payload   Beat is taken when
//   message   push / full        msg       push && !full
//   digest    empty / pop        digest    pop && !empty
//
// A 16-word block is loaded word by word into the expansion window, then runs
// through 64 rounds and a finishing step; the single round unit limits how
// fast message words are taken. A final beat adds padding words at one per
// cycle while the word queue has room, then the eight digest beats drain from
// an output buffer while the next message is already taken.
// Reset (rst, synchronous) restores the initial chaining value and zero length.
// full rises while the front end emits padding or when the word queue is full.
`default_nettype none
module sm3_hash
  import sm3_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  output logic         full,
  input  wire msg_t    msg,
  output logic         empty,
  input  wire logic    pop,
  output digest_t      digest
);

  logic  q_push, q_full, q_pop, q_empty;
  qent_t q_wdata, q_rdata;

  // Front end: every accepted beat becomes one or more padded block words.
  sm3_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .msg    (msg),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  // Word queue lets padding run ahead while the core is busy with rounds.
  sm3_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Compression core and digest output buffer.
  sm3_core u_core (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .digest  (digest)
  );

endmodule
`default_nettype wire

>>> dv/sm3_hash_tb.sv
// Self-checking testbench for the SM3 hash block: drives message words, predicts digests.
// Depends on sm3_pkg (msg_t, digest_t) and the sm3_hash top level.
`timescale 1ns / 100ps
module sm3_hash_tb;
  import sm3_pkg::*;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  msg_t    msg;
  logic    empty;
  logic    pop;
  digest_t digest;

  sm3_hash i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .msg    (msg),
    .empty  (empty),
    .pop    (pop),
    .digest (digest)
  );

  // Initial value and round constants of the hash, held locally.
  localparam logic [31:0] INIT_V [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };
  localparam logic [31:0] T_EARLY = 32'h79CC4519;
  localparam logic [31:0] T_LATE  = 32'h7A879D8A;

  // Predictor state: chaining value, current block words, fill count and bit length.
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  int          blk_fill;
  logic [63:0] msg_bits;

  msg_t    pending_words [$];   // beats waiting to be driven
  digest_t digest_expected [$]; // digest words not yet seen on the output

  int  errors;
  int  mismatches;
  bit  stim_done;
  int  hold_cycles;             // long receiver hold-off, counted down by the monitor
  int  n_queued;                // beats handed to the driver
  int  n_taken;                 // beats accepted by the block
  bit  in_taken;                // a message beat was accepted at the last rising edge

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] p0(logic [31:0] x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic logic [31:0] p1(logic [31:0] x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  // One compression of the 16 buffered words into the chaining value.
  task automatic compress_chain();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++)
      w[j] = p1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int j = 0; j < 64; j++) begin
      a12 = rol(a, 12);
      ss1 = rol(a12 + e + rol((j < 16) ? T_EARLY : T_LATE, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rol(b, 9); b = a; a = tt1;
      h = g; g = rol(f, 19); f = e; e = p0(tt2);
    end
    chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
    chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
  endtask

  task automatic add_block_word(logic [31:0] word);
    blk[blk_fill] = word;
    blk_fill = (blk_fill + 1) % 16;
    if (blk_fill == 0) compress_chain();
  endtask

  task automatic reset_hash();
    for (int k = 0; k < 8; k++) chain[k] = INIT_V[k];
    blk_fill = 0;
    msg_bits = '0;
  endtask

  // Advances the predictor by one accepted beat; a final beat pads the message
  // and queues the eight digest words it produces.
  task automatic hash_accept(msg_t m);
    int          nbytes;
    logic [31:0] keep;
    digest_t     dw;
    nbytes = m.byte_count;
    if (nbytes > 4 || !m.last) nbytes = 4;
    msg_bits += 64'(8 * nbytes);
    if (!m.last) begin
      add_block_word(m.msg_word);
    end else begin
      if (nbytes == 4) begin
        add_block_word(m.msg_word);
        add_block_word(32'h80000000);
      end else begin
        keep = (nbytes == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * nbytes));
        add_block_word((m.msg_word & keep) | (32'h80000000 >> (8 * nbytes)));
      end
      while (blk_fill != 14) add_block_word(32'h0);
      add_block_word(msg_bits[63:32]);
      add_block_word(msg_bits[31:0]);
      for (int k = 0; k < 8; k++) begin
        dw.digest_word = chain[k];
        dw.word_index  = 3'(k);
        dw.last_digest = (k == 7);
        digest_expected.insert(digest_expected.size(), dw);
      end
      reset_hash();
    end
  endtask

  // Random gap length: mostly none or short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Acceptance is judged from the handshake as it stood at the rising edge.
  always @(posedge clk) begin
    in_taken = !rst && push && !full;
  end

  // Driver: one beat offered at a time, changes made at the falling edge.
  int drv_gap;
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      msg  <= '0;
      drv_gap <= 0;
    end else if (in_taken) begin
      // The beat was taken at the last rising edge.
      hash_accept(msg);
      n_taken++;
      if (drv_gap == 0 && pending_words.size() > 0 && $urandom_range(0, 3) != 0) begin
        msg <= pending_words.pop_front();
      end else begin
        push    <= 1'b0;
        drv_gap <= gap_len();
      end
    end else if (!push) begin
      if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
      end else if (pending_words.size() > 0) begin
        push <= 1'b1;
        msg  <= pending_words.pop_front();
      end
    end
  end

  // Monitor: checks each digest beat at the rising edge, pop driven at the falling edge.
  int pop_gap;
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (digest_expected.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("Unexpected digest beat: %h", digest);
        mismatches++;
      end else begin
        digest_t exp_d;
        exp_d = digest_expected.pop_front();
        if (digest !== exp_d) begin
          errors++;
          if (mismatches < 10)
            $display("Digest mismatch: expected word %h index %0d last %b, got %h %0d %b",
                     exp_d.digest_word, exp_d.word_index, exp_d.last_digest,
                     digest.digest_word, digest.word_index, digest.last_digest);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_gap <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      pop <= 1'b0;
    end else if (stim_done && pending_words.size() == 0 && $urandom_range(0, 1)) begin
      // Extra chance of pop toward the end of the run.
      pop <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      pop <= 1'b0;
      pop_gap <= gap_len();
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic queue_beat(msg_t m);
    pending_words.insert(pending_words.size(), m);
    n_queued++;
  endtask

  task automatic queue_message(int nwords, int last_bytes);
    msg_t m;
    for (int i = 0; i < nwords; i++) begin
      m.msg_word   = $urandom();
      m.last       = (i == nwords - 1);
      m.byte_count = m.last ? 3'(last_bytes) : 3'd4;
      // Occasionally a partial count on a middle word, which counts as full.
      if (!m.last && $urandom_range(0, 19) == 0) m.byte_count = 3'($urandom_range(0, 7));
      queue_beat(m);
    end
  endtask

  initial begin
    msg_t m;
    int   n;
    errors = 0;
    mismatches = 0;
    stim_done = 1'b0;
    hold_cycles = 0;
    n_queued = 0;
    n_taken = 0;
    in_taken = 1'b0;
    reset_hash();
    rst  = 1'b1;
    push = 1'b0;
    pop  = 1'b0;
    msg  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: the standard "abc" message, an empty message, a zero-byte
    // final word, counts above four, all-ones and all-zeros words, and a
    // message that ends exactly at 14 words so padding spills a whole block.
    m = '{msg_word: 32'h61626300, byte_count: 3'd3, last: 1'b1};
    queue_beat(m);
    m = '{msg_word: 32'hFFFFFFFF, byte_count: 3'd0, last: 1'b1};
    queue_beat(m);
    m = '{msg_word: 32'hFFFFFFFF, byte_count: 3'd7, last: 1'b0};
    queue_beat(m);
    m = '{msg_word: 32'hFFFFFFFF, byte_count: 3'd5, last: 1'b1};
    queue_beat(m);
    m = '{msg_word: 32'h00000000, byte_count: 3'd1, last: 1'b1};
    queue_beat(m);
    m = '{msg_word: 32'hFFFFFFFF, byte_count: 3'd2, last: 1'b1};
    queue_beat(m);
    queue_message(14, 4);

    // Long receiver hold-off while the sender keeps going, so the block fills up.
    hold_cycles = 600;

    // Random part: whole messages of random length, mostly short.
    n = 0;
    while (n < 300) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 17);
      queue_message(len, $urandom_range(0, 4));
      n += len;
    end
    stim_done = 1'b1;

    wait (n_taken == n_queued);
    wait (digest_expected.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && digest_expected.size() == 0) begin
      $display("** sm3_hash: PASSED **");
    end else begin
      $display("** sm3_hash: FAILED **");
    end
    $finish;
  end

  // Run limit well above the slowest correct run.
  initial begin
    #(12 * 400000);
    $display("** sm3_hash: FAILED **");
    $finish;
  end

endmodule
